// File: sv/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
// No dependencies; take it in with `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, but also evaluated while reset is held.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/i2crs_pkg.sv
// Shared types and codes of the I2C register access sequencer.
// No dependencies; used by the interfaces and every module of the block.
package i2crs_pkg;

    localparam int OP_W    = 2;
    localparam int CNT_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 7;
    localparam int CMD_W   = 3;
    localparam int DONE_W  = 2;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 7;

    // input operation codes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_EVENT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_BUS_EN     = 2'd1;

    // controller commands
    localparam logic [CMD_W-1:0] CMD_NONE        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SINGLE_SEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEND_START  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEND_CONT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEND_FINISH = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RECV_START  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RECV_CONT   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RECV_FINISH = 3'd7;

    // completion kinds
    localparam logic [DONE_W-1:0] DONE_NONE  = 2'd0;
    localparam logic [DONE_W-1:0] DONE_WRITE = 2'd1;
    localparam logic [DONE_W-1:0] DONE_READ  = 2'd2;

    // what the datapath does with an accepted transaction
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_RD_REQ  = 3'd1,
        ACT_WR_REQ  = 3'd2,
        ACT_WR_FIN  = 3'd3,
        ACT_WR_DONE = 3'd4,
        ACT_RESTART = 3'd5,
        ACT_FILL    = 3'd6,
        ACT_DRAIN   = 3'd7
    } t_action;

    typedef struct packed {
        t_action act;
        logic    drain_load;
        logic    in_drain;
    } t_ctrl_cmd;

    typedef struct packed {
        logic bus_en;
        logic busy;
        logic wr_xfer;
        logic restarted;
        logic fin_pending;
        logic drain_last;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] target_address;
        logic              read_direction;
        logic [BYTE_W-1:0] tx_byte;
        logic [DONE_W-1:0] done_kind;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } t_out_item;

endpackage

// File: sv/i2crs_if.sv
// Channel interfaces of the sequencer: request/event input, result output,
// configuration write. Depend on i2crs_pkg for field widths.
interface i2crs_in_if import i2crs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] reg_index;
    logic [CNT_W-1:0]  byte_count;
    logic [BYTE_W-1:0] write_value;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, operation, reg_index, byte_count, write_value, rx_byte,
                    input ready);
    modport sink (input valid, operation, reg_index, byte_count, write_value, rx_byte,
                  output ready);
endinterface

interface i2crs_out_if import i2crs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] target_address;
    logic              read_direction;
    logic [BYTE_W-1:0] tx_byte;
    logic [DONE_W-1:0] done_kind;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, command, target_address, read_direction, tx_byte,
                    done_kind, data_byte, last, input ready);
    modport sink (input valid, command, target_address, read_direction, tx_byte,
                  done_kind, data_byte, last, output ready);
endinterface

interface i2crs_cfg_if import i2crs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/i2crs_ctrl.sv
// Sequencer controller: decodes accepted transactions against datapath
// status and paces the read-data drain. Depends on i2crs_pkg.
module i2crs_ctrl import i2crs_pkg::*; #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [OP_W-1:0]  i_operation,
    input  logic [CNT_W-1:0] i_byte_count,
    input  t_dp_status       i_status,
    output logic             o_in_ready,
    output t_ctrl_cmd        o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_action act;
    logic    accept;
    logic    cnt_ok;
    logic    drain_load;

    assign o_in_ready = (r_state == S_IDLE) && i_status.out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign cnt_ok     = (i_byte_count != '0) && (int'(i_byte_count) <= BUFFER_DEPTH);
    assign drain_load = (r_state == S_DRAIN) && i_status.out_free;

    always_comb begin
        act = ACT_NONE;
        if (accept) begin
            case (i_operation)
                OP_READ: begin
                    if (i_status.bus_en && !i_status.busy && cnt_ok) act = ACT_RD_REQ;
                end
                OP_WRITE: begin
                    if (i_status.bus_en && !i_status.busy) act = ACT_WR_REQ;
                end
                OP_EVENT: begin
                    if (i_status.busy) begin
                        if (i_status.wr_xfer) begin
                            act = i_status.fin_pending ? ACT_WR_DONE : ACT_WR_FIN;
                        end else if (!i_status.restarted) begin
                            act = ACT_RESTART;
                        end else if (i_status.fin_pending) begin
                            act = ACT_DRAIN;
                        end else begin
                            act = ACT_FILL;
                        end
                    end
                end
                default: act = ACT_NONE;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (act == ACT_DRAIN) n_state = S_DRAIN;
            S_DRAIN: if (drain_load && i_status.drain_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.act        = act;
    assign o_cmd.drain_load = drain_load;
    assign o_cmd.in_drain   = (r_state == S_DRAIN);

endmodule

// File: sv/i2crs_dp.sv
// Sequencer datapath: config registers, transfer state, read byte store
// and the result register. Depends on i2crs_pkg; driven by i2crs_ctrl.
module i2crs_dp import i2crs_pkg::*; #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  logic [BYTE_W-1:0] i_reg_index,
    input  logic [CNT_W-1:0]  i_byte_count,
    input  logic [BYTE_W-1:0] i_write_value,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_cfg_valid,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_out_ready,
    output t_dp_status        o_status,
    output logic              o_out_valid,
    output t_out_item         o_out
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [ADDR_W-1:0] r_slave_addr;
    logic              r_bus_en;
    logic              r_busy;
    logic              r_wr_xfer;
    logic              r_restarted;
    logic              r_waiting;
    logic [CW-1:0]     r_remaining;
    logic [CW-1:0]     r_req_cnt;
    logic [CW-1:0]     r_fill;
    logic [CW-1:0]     r_drain_idx;
    logic [BYTE_W-1:0] r_held;
    logic [BYTE_W-1:0] r_rd_data;
    logic [BYTE_W-1:0] r_mem [BUFFER_DEPTH];
    logic              r_out_valid;
    t_out_item         r_out;

    t_out_item         n_out;
    logic [CW-1:0]     n_drain_idx;
    logic              rem_one;
    logic              drain_last;
    logic              out_free;
    logic              loading;
    logic              go_idle;
    logic              mem_we;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    assign rem_one     = (r_remaining == CW'(1));
    assign n_drain_idx = r_drain_idx + CW'(1);
    assign drain_last  = (n_drain_idx == r_req_cnt);
    assign out_free    = !r_out_valid || i_out_ready;
    assign loading     = i_cmd.drain_load ||
                         ((i_cmd.act != ACT_NONE) && (i_cmd.act != ACT_DRAIN));
    assign go_idle     = (i_cmd.act == ACT_WR_DONE) || (i_cmd.drain_load && drain_last);
    assign mem_we      = (i_cmd.act == ACT_FILL) && (r_fill < CW'(BUFFER_DEPTH));
    assign rd_en       = (i_cmd.act == ACT_DRAIN) || i_cmd.drain_load;
    assign rd_addr     = (i_cmd.act == ACT_DRAIN) ? '0 : n_drain_idx[AW-1:0];

    // configuration writes are always taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= '0;
            r_bus_en     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SLAVE_ADDR: r_slave_addr <= i_cfg_data;
                CFG_BUS_EN:     r_bus_en     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_out = '0;
        if (i_cmd.drain_load) begin
            n_out.done_kind = DONE_READ;
            n_out.data_byte = r_rd_data;
            n_out.last      = drain_last;
        end else begin
            case (i_cmd.act)
                ACT_RD_REQ: begin
                    n_out.command        = CMD_SINGLE_SEND;
                    n_out.target_address = r_slave_addr;
                    n_out.tx_byte        = i_reg_index;
                end
                ACT_WR_REQ: begin
                    n_out.command        = CMD_SEND_START;
                    n_out.target_address = r_slave_addr;
                    n_out.tx_byte        = i_reg_index;
                end
                ACT_WR_FIN: begin
                    n_out.command = CMD_SEND_FINISH;
                    n_out.tx_byte = r_held;
                end
                ACT_WR_DONE: n_out.done_kind = DONE_WRITE;
                ACT_RESTART: begin
                    n_out.command        = CMD_RECV_START;
                    n_out.target_address = r_slave_addr;
                    n_out.read_direction = 1'b1;
                end
                ACT_FILL: n_out.command = rem_one ? CMD_RECV_FINISH : CMD_RECV_CONT;
                default: n_out = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_wr_xfer    <= 1'b0;
            r_restarted  <= 1'b0;
            r_waiting    <= 1'b0;
            r_remaining  <= '0;
            r_req_cnt    <= '0;
            r_fill       <= '0;
            r_drain_idx  <= '0;
            r_held       <= '0;
        end else begin
            case (i_cmd.act)
                ACT_RD_REQ: begin
                    r_busy       <= 1'b1;
                    r_wr_xfer    <= 1'b0;
                    r_restarted  <= 1'b0;
                    r_waiting    <= 1'b0;
                    // count already checked against the depth
                    r_remaining  <= CW'(i_byte_count);
                    r_req_cnt    <= CW'(i_byte_count);
                    r_fill       <= '0;
                end
                ACT_WR_REQ: begin
                    r_busy       <= 1'b1;
                    r_wr_xfer    <= 1'b1;
                    r_restarted  <= 1'b0;
                    r_waiting    <= 1'b0;
                    r_remaining  <= CW'(1);
                    r_held       <= i_write_value;
                end
                ACT_WR_FIN:  r_waiting <= 1'b1;
                ACT_RESTART: r_restarted <= 1'b1;
                ACT_FILL: begin
                    if (mem_we) r_fill <= r_fill + CW'(1);
                    r_remaining <= r_remaining - CW'(1);
                    if (rem_one) r_waiting <= 1'b1;
                end
                ACT_DRAIN: r_drain_idx <= '0;
                default: ;
            endcase
            if (i_cmd.drain_load) r_drain_idx <= n_drain_idx;
            if (go_idle) begin
                r_busy       <= 1'b0;
                r_wr_xfer    <= 1'b0;
                r_restarted  <= 1'b0;
                r_waiting    <= 1'b0;
                r_remaining  <= '0;
            end
        end
    end

    // read store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_fill[AW-1:0]] <= i_rx_byte;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (loading) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (loading) r_out <= n_out;
    end

    assign o_status.bus_en      = r_bus_en;
    assign o_status.busy        = r_busy;
    assign o_status.wr_xfer     = r_wr_xfer;
    assign o_status.restarted   = r_restarted;
    assign o_status.fin_pending = r_waiting;
    assign o_status.drain_last  = drain_last;
    assign o_status.out_free    = out_free;
    assign o_out_valid          = r_out_valid;
    assign o_out                = r_out;

endmodule

// File: sv/i2c_register_access_sequencer_top.sv
// Channel    Dir  Handshake     Payload
// i_in       in   valid/ready   operation, reg_index, byte_count, write_value, rx_byte
// o_out      out  valid/ready   command, target_address, read_direction, tx_byte,
//                               done_kind, data_byte, last
// i_cfg      in   valid/ready   index, data (ready always high)
//
// An accepted request or event other than a read's finish event loads at most one
// result into the output register, shown from the next cycle. The finish event of
// a read first reads the byte store through its registered read port, then
// delivers one byte per cycle while the output register is free.
// Input ready drops while the output register holds an untaken transaction
// and during the drain. Reset is synchronous; the byte store is not cleared.
//
// Top level of the I2C register access sequencer; depends on i2crs_pkg,
// the channel interfaces, i2crs_ctrl, i2crs_dp and assert_macros.svh.
`include "assert_macros.svh"

module i2c_register_access_sequencer_top import i2crs_pkg::*; #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2crs_in_if.sink    i_in,
    i2crs_out_if.source o_out,
    i2crs_cfg_if.sink   i_cfg
);

    t_ctrl_cmd  cmd;
    t_dp_status status;
    t_out_item  out_item;
    logic       in_ready;
    logic       out_valid;
    logic       rd_finishing;
    logic       last_shown;
    logic       load_over;

    i2crs_ctrl #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_operation  (i_in.operation),
        .i_byte_count (i_in.byte_count),
        .i_status     (status),
        .o_in_ready   (in_ready),
        .o_cmd        (cmd)
    );

    i2crs_dp #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_reg_index   (i_in.reg_index),
        .i_byte_count  (i_in.byte_count),
        .i_write_value (i_in.write_value),
        .i_rx_byte     (i_in.rx_byte),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_out.ready),
        .o_status      (status),
        .o_out_valid   (out_valid),
        .o_out         (out_item)
    );

    assign i_in.ready           = in_ready;
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = out_valid;
    assign o_out.command        = out_item.command;
    assign o_out.target_address = out_item.target_address;
    assign o_out.read_direction = out_item.read_direction;
    assign o_out.tx_byte        = out_item.tx_byte;
    assign o_out.done_kind      = out_item.done_kind;
    assign o_out.data_byte      = out_item.data_byte;
    assign o_out.last           = out_item.last;

    assign rd_finishing = status.busy && status.fin_pending && !status.wr_xfer;
    assign last_shown   = out_valid && out_item.last;
    assign load_over    = cmd.drain_load && out_valid;

    `ASSERT_CLK(a_drain_no_in, i_clk, i_rst_n, cmd.in_drain |-> !in_ready, "input during drain")
    `ASSERT_CLK(a_drain_rd, i_clk, i_rst_n, cmd.in_drain |-> rd_finishing, "drain outside read")
    `ASSERT_CLK(a_last_idle, i_clk, i_rst_n, last_shown |-> !status.busy, "last while busy")
    `ASSERT_CLK(a_drain_room, i_clk, i_rst_n, load_over |-> o_out.ready, "drain overwrite")

endmodule

// File: dv/i2c_register_access_sequencer_top_tb.sv
// Self-checking testbench for the I2C register access sequencer top level.
// Drives requests and controller events, predicts every result transaction and
// compares it; depends on i2crs_pkg, the channel interfaces and the top module.
`timescale 1ns / 1ps

module i2c_register_access_sequencer_top_tb;
    import i2crs_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int BUF_DEPTH       = 32;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 2 * BUF_DEPTH + 8;
    localparam int RAND_PHASES     = 5;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int LIMIT_CYCLES    = 400000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] idx;
        logic [CNT_W-1:0]  cnt;
        logic [BYTE_W-1:0] wval;
        logic [BYTE_W-1:0] rx;
    } t_bus_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2crs_in_if  in_ch ();
    i2crs_out_if out_ch ();
    i2crs_cfg_if cfg_ch ();

    i2c_register_access_sequencer_top #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_bus_item  bus_items[$];
    t_out_item  expected_outputs[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         in_gap      = 0;
    int         out_gap     = 0;
    bit         idle_on     = 1'b1;

    // predictor copy of the registers and sequencing state
    logic [ADDR_W-1:0] cfg_addr_q      = '0;
    logic              cfg_en_q        = 1'b0;
    logic              seq_busy        = 1'b0;
    logic              seq_write       = 1'b0;
    logic              seq_restarted   = 1'b0;
    logic              seq_wait_fin    = 1'b0;
    logic [CNT_W-1:0]  bytes_left      = '0;
    logic [CNT_W-1:0]  bytes_req       = '0;
    int                fill_ptr        = 0;
    logic [BYTE_W-1:0] held_byte       = '0;
    logic [BYTE_W-1:0] byte_store [BUF_DEPTH];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    function automatic void seq_go_idle();
        seq_busy      = 1'b0;
        seq_write     = 1'b0;
        seq_restarted = 1'b0;
        seq_wait_fin  = 1'b0;
        bytes_left    = '0;
    endfunction

    task automatic predict_sequencer_outputs(input t_bus_item it);
        t_out_item r;
        int        n;
        r = '0;
        if (it.op == OP_READ || it.op == OP_WRITE) begin
            if (cfg_en_q && !seq_busy) begin
                if (it.op == OP_READ) begin
                    if (it.cnt != 0 && it.cnt <= BUF_DEPTH) begin
                        seq_busy         = 1'b1;
                        seq_write        = 1'b0;
                        seq_restarted    = 1'b0;
                        seq_wait_fin     = 1'b0;
                        bytes_left       = it.cnt;
                        bytes_req        = it.cnt;
                        fill_ptr         = 0;
                        r.command        = CMD_SINGLE_SEND;
                        r.target_address = cfg_addr_q;
                        r.tx_byte        = it.idx;
                        expected_outputs.push_back(r);
                    end
                end else begin
                    seq_busy         = 1'b1;
                    seq_write        = 1'b1;
                    seq_restarted    = 1'b0;
                    seq_wait_fin     = 1'b0;
                    bytes_left       = CNT_W'(1);
                    held_byte        = it.wval;
                    r.command        = CMD_SEND_START;
                    r.target_address = cfg_addr_q;
                    r.tx_byte        = it.idx;
                    expected_outputs.push_back(r);
                end
            end
        end else if (it.op == OP_EVENT && seq_busy) begin
            if (seq_write) begin
                if (seq_wait_fin) begin
                    seq_go_idle();
                    r.done_kind = DONE_WRITE;
                end else begin
                    seq_wait_fin = 1'b1;
                    r.command    = CMD_SEND_FINISH;
                    r.tx_byte    = held_byte;
                end
                expected_outputs.push_back(r);
            end else if (!seq_restarted) begin
                seq_restarted    = 1'b1;
                r.command        = CMD_RECV_START;
                r.target_address = cfg_addr_q;
                r.read_direction = 1'b1;
                expected_outputs.push_back(r);
            end else if (seq_wait_fin) begin
                n = (bytes_req > BUF_DEPTH) ? BUF_DEPTH : int'(bytes_req);
                for (int k = 0; k < n; k++) begin
                    r           = '0;
                    r.done_kind = DONE_READ;
                    r.data_byte = byte_store[k];
                    r.last      = (k == n - 1);
                    expected_outputs.push_back(r);
                end
                seq_go_idle();
            end else begin
                if (fill_ptr < BUF_DEPTH) begin
                    byte_store[fill_ptr] = it.rx;
                    fill_ptr++;
                end
                if (bytes_left > 0)
                    bytes_left--;
                if (bytes_left == 0) begin
                    seq_wait_fin = 1'b1;
                    r.command    = CMD_RECV_FINISH;
                end else begin
                    r.command = CMD_RECV_CONT;
                end
                expected_outputs.push_back(r);
            end
        end
    endtask

    // input driver: pops the pending queue, inserts random idle bursts while idle_on is set
    always @(posedge i_clk) begin
        t_bus_item nxt;
        if (!i_rst_n) begin
            in_ch.valid       <= 1'b0;
            in_ch.operation   <= '0;
            in_ch.reg_index   <= '0;
            in_ch.byte_count  <= '0;
            in_ch.write_value <= '0;
            in_ch.rx_byte     <= '0;
            in_gap            <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_gap > 0) begin
                in_gap      <= in_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (bus_items.size() != 0) begin
                if (idle_on && $urandom_range(0, 4) == 0) begin
                    in_gap      <= $urandom_range(0, 5);
                    in_ch.valid <= 1'b0;
                end else begin
                    nxt               = bus_items.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.operation   <= nxt.op;
                    in_ch.reg_index   <= nxt.idx;
                    in_ch.byte_count  <= nxt.cnt;
                    in_ch.write_value <= nxt.wval;
                    in_ch.rx_byte     <= nxt.rx;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap      <= 0;
        end else if (out_gap > 0) begin
            out_gap      <= out_gap - 1;
            out_ch.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_gap      <= $urandom_range(0, 5);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // accepted input transaction -> prediction
    always @(posedge i_clk) begin
        t_bus_item it;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            it.op   = in_ch.operation;
            it.idx  = in_ch.reg_index;
            it.cnt  = in_ch.byte_count;
            it.wval = in_ch.write_value;
            it.rx   = in_ch.rx_byte;
            predict_sequencer_outputs(it);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.index)
                CFG_SLAVE_ADDR: cfg_addr_q = cfg_ch.data[ADDR_W-1:0];
                CFG_BUS_EN:     cfg_en_q   = cfg_ch.data[0];
                default: ;
            endcase
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected result cmd %0d done %0d data %h",
                                          out_ch.command, out_ch.done_kind,
                                          out_ch.data_byte));
            end else begin
                want = expected_outputs.pop_front();
                check_field("command", 8'(out_ch.command), 8'(want.command));
                check_field("target_address", 8'(out_ch.target_address),
                            8'(want.target_address));
                check_field("read_direction", 8'(out_ch.read_direction),
                            8'(want.read_direction));
                check_field("tx_byte", out_ch.tx_byte, want.tx_byte);
                check_field("done_kind", 8'(out_ch.done_kind), 8'(want.done_kind));
                check_field("data_byte", out_ch.data_byte, want.data_byte);
                check_field("last", 8'(out_ch.last), 8'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void queue_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] idx,
                                       input logic [CNT_W-1:0] cnt,
                                       input logic [BYTE_W-1:0] wval,
                                       input logic [BYTE_W-1:0] rx);
        t_bus_item it;
        it.op   = op;
        it.idx  = idx;
        it.cnt  = cnt;
        it.wval = wval;
        it.rx   = rx;
        bus_items.push_back(it);
    endfunction

    // controller event with junk in the fields it does not use
    function automatic void queue_event(input logic [BYTE_W-1:0] rx);
        queue_item(OP_EVENT, BYTE_W'($urandom), CNT_W'($urandom), BYTE_W'($urandom), rx);
    endfunction

    // read of n bytes: request, restart, n fills, finish; only the first keep items
    function automatic int queue_read(input int n, input int keep);
        int pushed;
        pushed = 0;
        for (int k = 0; k < n + 3 && k < keep; k++) begin
            if (k == 0)
                queue_item(OP_READ, BYTE_W'($urandom), CNT_W'(n), BYTE_W'($urandom),
                           BYTE_W'($urandom));
            else
                queue_event(BYTE_W'($urandom));
            pushed++;
        end
        return pushed;
    endfunction

    function automatic int queue_write(input int keep);
        int pushed;
        pushed = 0;
        for (int k = 0; k < 3 && k < keep; k++) begin
            if (k == 0)
                queue_item(OP_WRITE, BYTE_W'($urandom), CNT_W'($urandom), BYTE_W'($urandom),
                           BYTE_W'($urandom));
            else
                queue_event(BYTE_W'($urandom));
            pushed++;
        end
        return pushed;
    endfunction

    task automatic write_register(input logic [CFG_IW-1:0] idx,
                                  input logic [CFG_DW-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // all stimulus taken and all results seen, then let any silent work finish
    task automatic wait_drained();
        do @(posedge i_clk);
        while (bus_items.size() != 0 || in_ch.valid || expected_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int               ph;
        int               queued;
        int               pick;
        int               n;
        logic [ADDR_W-1:0] addr;

        i_rst_n           <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= '0;
        cfg_ch.data       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bus not enabled yet: everything ignored
        queue_item(OP_READ, 8'hAA, 6'd2, 8'h00, 8'h00);
        queue_item(OP_WRITE, 8'h55, 6'd0, 8'h12, 8'h00);
        queue_event(8'h34);
        wait_drained();

        write_register(CFG_SLAVE_ADDR, 7'h7F);
        write_register(CFG_BUS_EN, 7'h7F);

        // writes at the byte extremes
        queue_item(OP_WRITE, 8'hFF, 6'd63, 8'h00, 8'hFF);
        queue_event(8'h00);
        queue_event(8'hFF);
        queue_item(OP_WRITE, 8'h00, 6'd0, 8'hFF, 8'h00);
        queue_event(8'h00);
        queue_event(8'h00);
        // rejected counts, unused opcode, event while idle
        queue_item(OP_READ, 8'h11, 6'd0, 8'h00, 8'h00);
        queue_item(OP_READ, 8'h22, 6'd33, 8'h00, 8'h00);
        queue_item(OP_READ, 8'h33, 6'd63, 8'hFF, 8'hFF);
        queue_item(OP_UNUSED, 8'hFF, 6'd1, 8'hFF, 8'hFF);
        queue_event(8'h77);
        // one-byte read with requests arriving while busy
        queue_item(OP_READ, 8'h5A, 6'd1, 8'h00, 8'h00);
        queue_item(OP_WRITE, 8'h66, 6'd0, 8'h99, 8'h00);
        queue_item(OP_READ, 8'h44, 6'd3, 8'h00, 8'h00);
        queue_event(8'h00);
        queue_event(8'hFF);
        queue_event(8'h00);
        // leave a read mid-transfer for the register changes below
        queue_item(OP_READ, 8'h3C, 6'd2, 8'h00, 8'h00);
        queue_event(8'h00);
        wait_drained();

        // new address and bus disable take effect while the read is open
        write_register(CFG_SLAVE_ADDR, 7'h00);
        write_register(CFG_BUS_EN, 7'h7E);
        queue_item(OP_READ, 8'h01, 6'd1, 8'h00, 8'h00);
        queue_event(8'h00);
        queue_event(8'hA5);
        queue_event(8'h00);
        queue_item(OP_WRITE, 8'h02, 6'd0, 8'h03, 8'h00);
        wait_drained();
        write_register(CFG_BUS_EN, 7'h01);

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            idle_on = (ph != RAND_PHASES - 1);
            case (ph)
                1:       addr = 7'h7F;
                2:       addr = 7'h00;
                default: addr = ADDR_W'($urandom);
            endcase
            write_register(CFG_SLAVE_ADDR, addr);
            queued = 0;
            if (ph == 0 || ph == RAND_PHASES - 1)
                queued += queue_read(BUF_DEPTH, BUF_DEPTH + 3);
            while (queued < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, BUF_DEPTH)
                                                    : $urandom_range(1, 4);
                    queued += queue_read(n, n + 3);
                end else if (pick < 75) begin
                    queued += queue_write(3);
                end else if (pick < 85) begin
                    n = $urandom_range(1, 4);
                    queued += queue_read(n, $urandom_range(1, n + 2));
                end else if (pick < 90) begin
                    queued += queue_write($urandom_range(1, 2));
                end else begin
                    queue_item(OP_W'($urandom), BYTE_W'($urandom), CNT_W'($urandom),
                               BYTE_W'($urandom), BYTE_W'($urandom));
                    queued++;
                end
            end
            wait_drained();
        end

        if (expected_outputs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_outputs.size()));
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
